[rtl/core/chained_hash_find_or_insert_defines.svh]
// assertion macros for the chained hash find-or-insert block
`ifndef CHAINED_HASH_FIND_OR_INSERT_DEFINES_SVH
`define CHAINED_HASH_FIND_OR_INSERT_DEFINES_SVH

// property that holds at every clock edge out of reset
`define CHF_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property that holds on the clock edge after a condition
`define CHF_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

[rtl/core/chf_pkg.sv]
// types, codes and defaults shared by the chained hash find-or-insert block
package chf_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int BUCKET_COUNT_DEF  = 256;

  localparam int KEY_W       = 32;
  localparam int VER_W       = 16;
  localparam int ENTRY_IDX_W = 10;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_MOD_SUB,
    S_HEAD,
    S_HEAD_DATA,
    S_CHECK,
    S_CMP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_hash;
    logic [VER_W-1:0] first_version;
  } in_item_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] entry_index;
    status_t                status;
    logic [VER_W-1:0]       version_now;
  } out_item_t;

endpackage

[rtl/core/chf_ram.sv]
// generic single write port ram with registered read
module chf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/chained_hash_find_or_insert.sv]
// top level of the chained hash find-or-insert block
// an accepted item goes to S_HEAD and S_HEAD_DATA for the bucket head read, then to
//   S_CHECK; each chain entry passed over adds S_CMP and S_CHECK, a hit adds S_CMP; S_MOD
//   and S_MOD_SUB come first when BUCKET_COUNT is not a power of two; the result is registered
// a new item is taken only in S_IDLE, after the last result is issued; reset: after rst_n rises
//   a clearing pass writes every bucket head with in_stall high; entry count and output valid clear at once
`include "chained_hash_find_or_insert_defines.svh"

module chained_hash_find_or_insert
  import chf_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int BUCKET_COUNT  = BUCKET_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int AW      = $clog2(TABLE_ENTRIES);
  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int STEP_W  = IDX_W + 1;
  localparam int EW      = KEY_W + IDX_W + VER_W;
  localparam int MUL_W   = 2 * KEY_W + 1;
  localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam logic [IDX_W-1:0] NO_ENTRY = IDX_W'(TABLE_ENTRIES);
  localparam logic [KEY_W:0]   RECIP    =
    (KEY_W+1)'(((64'd1 << (KEY_W + BKT_W)) / 64'(BUCKET_COUNT)) + 64'd1);

  state_t            state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VER_W-1:0]  ver_r, ver_nxt;
  logic [BKT_W-1:0]  bucket_r, bucket_nxt;
  logic [KEY_W-1:0]  quot_r, quot_nxt;
  logic [BKT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              head_we;
  logic [BKT_W-1:0]  head_waddr;
  logic [IDX_W-1:0]  head_wdata;
  logic [IDX_W-1:0]  head_rdata;

  logic              ent_we;
  logic [AW-1:0]     ent_waddr;
  logic [EW-1:0]     ent_wdata;
  logic [EW-1:0]     ent_rdata;
  logic [KEY_W-1:0]  ent_key;
  logic [IDX_W-1:0]  ent_link;
  logic [VER_W-1:0]  ent_ver;

  logic [MUL_W-1:0]  mod_prod;
  logic [KEY_W-1:0]  mod_back;
  logic [KEY_W-1:0]  mod_rem;
  logic              can_emit;
  logic              walk_ok;
  logic              do_insert;
  logic              full_out;

  chf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (BUCKET_COUNT)
  ) u_heads (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_addr (bucket_r),
    .rd_data (head_rdata)
  );

  chf_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_addr (cur_r[AW-1:0]),
    .rd_data (ent_rdata)
  );

  assign ent_key  = ent_rdata[EW-1 -: KEY_W];
  assign ent_link = ent_rdata[VER_W +: IDX_W];
  assign ent_ver  = ent_rdata[VER_W-1:0];

  assign mod_prod = MUL_W'(key_r) * MUL_W'(RECIP);
  assign mod_back = quot_r * KEY_W'(BUCKET_COUNT);
  assign mod_rem  = key_r - mod_back;

  assign can_emit = !out_valid_r || !out_stall;
  assign walk_ok  = (cur_r < count_r) && (cur_r < NO_ENTRY) &&
                    (steps_r <= STEP_W'(count_r));
  assign full_out = out_valid_r && (out_data_r.status == ST_FULL);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    ver_nxt       = ver_r;
    bucket_nxt    = bucket_r;
    quot_nxt      = quot_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    head_we       = 1'b0;
    head_waddr    = bucket_r;
    head_wdata    = count_r;
    ent_we        = 1'b0;
    ent_waddr     = count_r[AW-1:0];
    ent_wdata     = {key_r, head_rdata, ver_r};
    do_insert     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_r;
        head_wdata = NO_ENTRY;
        if (clr_cnt_r == BKT_W'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + BKT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.key_hash;
          ver_nxt = in_data.first_version;
          if (IS_POW2) begin
            bucket_nxt = in_data.key_hash[BKT_W-1:0];
            state_nxt  = S_HEAD;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        // bucket quotient by reciprocal multiplication
        quot_nxt  = KEY_W'(mod_prod >> (KEY_W + BKT_W));
        state_nxt = S_MOD_SUB;
      end
      S_MOD_SUB: begin
        bucket_nxt = mod_rem[BKT_W-1:0];
        state_nxt  = S_HEAD;
      end
      S_HEAD: begin
        state_nxt = S_HEAD_DATA;
      end
      S_HEAD_DATA: begin
        cur_nxt   = head_rdata;
        steps_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (walk_ok) begin
          state_nxt = S_CMP;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (count_r >= NO_ENTRY) begin
            out_data_nxt.entry_index = '0;
            out_data_nxt.status      = ST_FULL;
            out_data_nxt.version_now = '0;
          end else begin
            // new entry goes in at the head of its chain
            do_insert  = 1'b1;
            ent_we     = 1'b1;
            head_we    = 1'b1;
            count_nxt  = count_r + IDX_W'(1);
            out_data_nxt.entry_index = ENTRY_IDX_W'(count_r);
            out_data_nxt.status      = ST_INSERTED;
            out_data_nxt.version_now = ver_r;
          end
        end
      end
      S_CMP: begin
        if (ent_key == key_r) begin
          if (can_emit) begin
            ent_we        = 1'b1;
            ent_waddr     = cur_r[AW-1:0];
            ent_wdata     = {ent_key, ent_link, ent_ver + VER_W'(1)};
            out_valid_nxt = 1'b1;
            out_data_nxt.entry_index = ENTRY_IDX_W'(cur_r);
            out_data_nxt.status      = ST_FOUND;
            out_data_nxt.version_now = ent_ver + VER_W'(1);
            state_nxt     = S_IDLE;
          end
        end else begin
          cur_nxt   = ent_link;
          steps_nxt = steps_r + STEP_W'(1);
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    ver_r      <= ver_nxt;
    bucket_r   <= bucket_nxt;
    quot_r     <= quot_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    out_data_r <= out_data_nxt;
  end

  `CHF_ASSERT(a_count_bound, count_r <= NO_ENTRY, "entry count above table size")
  `CHF_ASSERT_NEXT(a_insert_count, do_insert, count_r == $past(count_r) + IDX_W'(1), "insert lost")
  `CHF_ASSERT(a_cmp_in_range, (state_r != S_CMP) || (cur_r < count_r), "unwritten entry read")
  `CHF_ASSERT(a_full_status, !full_out || (count_r == NO_ENTRY), "full reported with free entries")

endmodule

[verif/chf_lookup_checker.sv]
`timescale 1ns / 1ps
// checker that predicts and compares every result of the chained hash find-or-insert block
module chf_lookup_checker
  import chf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        awaited_count,
  output int        hit_count,
  output int        insert_count,
  output int        refusal_count
);

  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam int BUCKETS = BUCKET_COUNT_DEF;
  localparam logic [10:0] NO_LINK = 11'(ENTRIES);

  logic [10:0]      chain_head [BUCKETS];
  logic [KEY_W-1:0] stored_key [ENTRIES];
  logic [10:0]      next_link  [ENTRIES];
  logic [VER_W-1:0] stored_ver [ENTRIES];
  int unsigned      entries_used;
  out_item_t        awaited_results [$];
  out_item_t        want;
  int               fails;
  int               hits;
  int               inserts;
  int               refusals;

  function automatic out_item_t find_or_insert(input in_item_t item);
    int unsigned bucket;
    int unsigned slot;
    int unsigned hops;
    out_item_t   res;
    bucket = item.key_hash % BUCKETS;
    slot = chain_head[bucket];
    hops = 0;
    while (slot < entries_used && slot < ENTRIES && hops <= entries_used) begin
      if (stored_key[slot] == item.key_hash) begin
        stored_ver[slot] = stored_ver[slot] + 1'b1;
        res.entry_index = ENTRY_IDX_W'(slot);
        res.status = ST_FOUND;
        res.version_now = stored_ver[slot];
        return res;
      end
      slot = next_link[slot];
      hops++;
    end
    if (entries_used >= ENTRIES) begin
      res.entry_index = '0;
      res.status = ST_FULL;
      res.version_now = '0;
      return res;
    end
    slot = entries_used;
    entries_used++;
    stored_key[slot] = item.key_hash;
    stored_ver[slot] = item.first_version;
    next_link[slot] = chain_head[bucket];
    chain_head[bucket] = 11'(slot);
    res.entry_index = ENTRY_IDX_W'(slot);
    res.status = ST_INSERTED;
    res.version_now = item.first_version;
    return res;
  endfunction

  task automatic note_failure(input string what, input bit has_want, input out_item_t exp_item);
    fails++;
    if (fails <= 10) begin
      if (has_want)
        $display("%0t %s: expected index %0d status %0d version %0d, got index %0d status %0d version %0d",
                 $time, what, exp_item.entry_index, exp_item.status, exp_item.version_now,
                 out_data.entry_index, out_data.status, out_data.version_now);
      else
        $display("%0t %s: got index %0d status %0d version %0d",
                 $time, what, out_data.entry_index, out_data.status, out_data.version_now);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUCKETS; b++) chain_head[b] = NO_LINK;
      entries_used = 0;
      awaited_results.delete();
      fails = 0;
      hits = 0;
      inserts = 0;
      refusals = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_failure("result with nothing awaited", 1'b0, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.entry_index !== want.entry_index || out_data.status !== want.status ||
              out_data.version_now !== want.version_now)
            note_failure("result mismatch", 1'b1, want);
        end
      end
      if (in_valid && !in_stall) begin
        want = find_or_insert(in_data);
        case (want.status)
          ST_FOUND: hits++;
          ST_INSERTED: inserts++;
          default: refusals++;
        endcase
        awaited_results.push_back(want);
      end
    end
    fail_count <= fails;
    awaited_count <= awaited_results.size();
    hit_count <= hits;
    insert_count <= inserts;
    refusal_count <= refusals;
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// testbench top for the chained hash find-or-insert block: reset, stimulus and verdict
module tb;
  import chf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned FILL_TARGET = 520;
  localparam int unsigned TAIL_ITEMS  = 180;
  localparam int unsigned HOLD_START  = 1500;
  localparam int unsigned HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int awaited_count;
  int hit_count;
  int insert_count;
  int refusal_count;

  logic [KEY_W-1:0] sent_keys [$];
  int unsigned      transfers;
  int unsigned      calm_left;
  int unsigned      cycle_count;
  int unsigned      seg_left;
  bit               seg_stall;

  always #5 clk = ~clk;

  chained_hash_find_or_insert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  chf_lookup_checker results_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .hit_count     (hit_count),
    .insert_count  (insert_count),
    .refusal_count (refusal_count)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // one new key in ten lands in one of four buckets so that long chains build up
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    if ($urandom_range(9) == 0) k[7:0] = 8'($urandom_range(3));
    return k;
  endfunction

  task automatic offer(input logic [KEY_W-1:0] k, input logic [VER_W-1:0] v);
    int unsigned pause;
    if (calm_left > 0) begin
      calm_left--;
      pause = 0;
    end else begin
      pause = idle_len();
      if ($urandom_range(99) == 0) calm_left = $urandom_range(60, 20);
    end
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {k, v};
    do @(posedge clk); while (in_stall);
    transfers++;
  endtask

  task automatic offer_new(input logic [KEY_W-1:0] k, input logic [VER_W-1:0] v);
    sent_keys.push_back(k);
    offer(k, v);
  endtask

  function automatic logic [KEY_W-1:0] known_key();
    return sent_keys[$urandom_range(sent_keys.size() - 1)];
  endfunction

  task automatic stall_step();
    if (seg_left == 0) begin
      seg_stall = !seg_stall;
      if (seg_stall)
        seg_left = idle_len() + 1;
      else if ($urandom_range(19) == 0)
        seg_left = $urandom_range(150, 50);
      else
        seg_left = $urandom_range(8, 1);
    end
    out_stall <= seg_stall;
    seg_left--;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    calm_left = 0;
    transfers = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of key and version, wrap of the version
    offer_new(32'h0000_0000, 16'h0000);
    offer(32'h0000_0000, 16'h1234);
    offer_new(32'hFFFF_FFFF, 16'hFFFF);
    offer(32'hFFFF_FFFF, 16'h0000);
    offer(32'hFFFF_FFFF, 16'hFFFF);
    // same bucket, different key, then a hit behind the new head
    offer_new(32'h0000_0100, 16'h8000);
    offer(32'h0000_0000, 16'h5555);
    // a longer chain, keys differing only in the top bit among them
    offer_new(32'h0000_005A, 16'hAAAA);
    offer_new(32'h8000_005A, 16'h0001);
    for (n = 0; n < 6; n++) offer_new({24'($urandom), 8'h5A}, 16'($urandom));
    offer(32'h0000_005A, 16'h0000);
    offer(32'h8000_005A, 16'hFFFF);
    offer_new(32'h7FFF_FFFF, 16'h7FFF);
    offer(32'hFFFF_FFFF, 16'h0000);

    // grow the table with a mix of new keys and repeats
    while (sent_keys.size() < FILL_TARGET) begin
      if ($urandom_range(99) < 85)
        offer_new(fresh_key(), 16'($urandom));
      else
        offer(known_key(), 16'($urandom));
    end
    // even mix of hits and misses on the grown table
    repeat (TAIL_ITEMS) begin
      if ($urandom_range(1) == 0)
        offer(known_key(), 16'($urandom));
      else
        offer(fresh_key(), 16'($urandom));
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (awaited_count != 0);
    repeat (100) @(posedge clk);
    @(negedge clk);
    $display("%0d transfers checked: %0d hits, %0d new entries, %0d refused as full",
             transfers, hit_count, insert_count, refusal_count);
    $display("random idling on both sides, one %0d-cycle hold on the result side",
             HOLD_CYCLES);
    if (fail_count == 0)
      $display("PASS chained_hash_find_or_insert");
    else
      $display("FAIL chained_hash_find_or_insert");
    $finish;
  end

  initial begin : result_side
    seg_left = 0;
    seg_stall = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (HOLD_START) stall_step();
    // long hold so the block backs up and stalls its input
    out_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    forever stall_step();
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL chained_hash_find_or_insert");
    $finish;
  end

endmodule
